[design/refcounted_handle_registry_unit_defines.svh]
// ----------------------------------------------------------------------------
// refcounted handle registry - assertion macros
// shared property shapes for the registry checker
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_HANDLE_REGISTRY_UNIT_DEFINES_SVH
`define REFCOUNTED_HANDLE_REGISTRY_UNIT_DEFINES_SVH

// same-cycle implication, masked while in reset
`define RHR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while in reset
`define RHR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define RHR_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rhr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhr_pkg
// types and fixed field widths of the refcounted handle registry
// ----------------------------------------------------------------------------
package rhr_pkg;

    localparam int MODE_W      = 2;
    localparam int DEVICE_W    = 6;
    localparam int SLOT_IDX_W  = 4;
    localparam int STATUS_W    = 3;
    localparam int LIVE_W      = 5;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [MODE_W-1:0] {
        MODE_REGISTER   = 2'd0,
        MODE_UNREGISTER = 2'd1,
        MODE_GET        = 2'd2,
        MODE_PUT        = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_NODEV    = 3'd1,
        STAT_INUSE    = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_NOTFOUND = 3'd4,
        STAT_REFUSED  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_REG_CHK,
        ST_UNREG_WR,
        ST_UNREG_REF,
        ST_TRIM,
        ST_GET_CHK,
        ST_GET_REF,
        ST_PUT_CHK,
        ST_EMIT
    } t_state;

    // write-back kinds for the per-identity record
    typedef enum logic [2:0] {
        REF_CLEAR,
        REF_CLAIM,
        REF_TAKE,
        REF_DROP,
        REF_RETIRE
    } t_ref_op;

    typedef struct packed {
        logic    rd;
        logic    wr;
        t_ref_op op;
    } t_ref_cmd;

    typedef struct packed {
        logic busy;
        logic at_max;
        logic put_refused;
        logic last_ref;
    } t_ref_stat;

endpackage

[design/refcounted_handle_registry_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_handle_registry_unit
// slot table of device identities with a reference count per identity
// ----------------------------------------------------------------------------
// register: a slot scan reading one slot per cycle up to the limit, then the claim;
// unregister: a slot scan, the free, then a trim of each trailing empty slot;
// get: slot read, then reference take; put: one record update; bad device: straight out.
// one transaction in flight; the next is taken the cycle after the result is
// loaded into the output register. the slot memory read port sets the scan rate.
// reset: a clearing pass over every slot and identity record with tready low.
module refcounted_handle_registry_unit #(
    parameter int SLOTS       = 16,
    parameter int IDENTITIES  = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // device [5:0], slot_index [9:6], zero fill
    input  logic [rhr_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // mode [1:0]
    input  logic [rhr_pkg::MODE_W-1:0]         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // status [2:0], device_out [8:3], slot_out [12:9], release_res [13],
    // live_count [18:14], index_limit [23:19]
    output logic [rhr_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    localparam int SAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IAW   = $clog2(IDENTITIES);
    localparam int LW    = $clog2(SLOTS + 1);
    localparam int CLR_N = (SLOTS > IDENTITIES) ? SLOTS : IDENTITIES;
    localparam int CW    = $clog2(CLR_N);

    // control state
    rhr_pkg::t_state r_state, n_state;
    logic [LW-1:0]   r_limit, n_limit;
    logic [LW-1:0]   r_live, n_live;
    logic [CW-1:0]   r_clr, n_clr;
    logic            r_out_valid, n_out_valid;
    logic            r_q_v;

    // payload
    rhr_pkg::t_mode   r_mode, n_mode;
    logic [IAW-1:0]   r_dev, n_dev;
    logic [LW-1:0]    r_ptr, n_ptr;
    logic             r_vac_ok, n_vac_ok;
    logic [SAW-1:0]   r_vac, n_vac;
    logic [SAW-1:0]   r_hit, n_hit;
    rhr_pkg::t_status r_res_status, n_res_status;
    logic [rhr_pkg::DEVICE_W-1:0]   r_res_dev, n_res_dev;
    logic [rhr_pkg::SLOT_IDX_W-1:0] r_res_slot, n_res_slot;
    logic             r_res_rel, n_res_rel;
    logic [rhr_pkg::OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // slot memory
    logic [IAW-1:0] mem_slot [SLOTS];
    logic [IAW-1:0] r_slot_q;
    logic [SAW-1:0] r_q_idx;
    logic           slot_we, slot_re;
    logic [SAW-1:0] slot_wa, slot_ra;
    logic [IAW-1:0] slot_wd;

    // identity record store
    rhr_pkg::t_ref_cmd  ref_cmd;
    rhr_pkg::t_ref_stat ref_stat;
    logic [IAW-1:0]     ref_addr;

    // input decode
    rhr_pkg::t_mode                 in_mode;
    logic [rhr_pkg::DEVICE_W-1:0]   in_dev;
    logic [rhr_pkg::SLOT_IDX_W-1:0] in_idx;
    logic in_acc, in_dev_bad, get_in_range, out_free;
    logic scan_hit, scan_vac, scan_end, trim_more;

    assign in_mode      = rhr_pkg::t_mode'(i_s_axis_tuser);
    assign in_dev       = i_s_axis_tdata[5:0];
    assign in_idx       = i_s_axis_tdata[9:6];
    assign in_dev_bad   = (in_dev == '0) || (32'(in_dev) >= IDENTITIES);
    assign get_in_range = 32'(in_idx) < 32'(r_limit);

    assign o_s_axis_tready = (r_state == rhr_pkg::ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign scan_hit  = r_q_v && (r_slot_q == r_dev);
    assign scan_vac  = r_q_v && (r_slot_q == '0) && !r_vac_ok;
    assign scan_end  = !r_q_v && (r_ptr == r_limit);
    assign trim_more = (r_slot_q == '0) && (r_limit != LW'(1));

    rhr_ref_table #(
        .IDENTITIES  (IDENTITIES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ref_table (
        .i_clk  (i_clk),
        .i_addr (ref_addr),
        .i_cmd  (ref_cmd),
        .o_stat (ref_stat)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rhr_pkg::ST_CLEAR: begin
                if (r_clr == CW'(CLR_N - 1)) n_state = rhr_pkg::ST_IDLE;
            end
            rhr_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (in_mode == rhr_pkg::MODE_GET) begin
                        n_state = get_in_range ? rhr_pkg::ST_GET_CHK : rhr_pkg::ST_EMIT;
                    end else if (in_dev_bad) begin
                        n_state = rhr_pkg::ST_EMIT;
                    end else if (in_mode == rhr_pkg::MODE_PUT) begin
                        n_state = rhr_pkg::ST_PUT_CHK;
                    end else begin
                        n_state = rhr_pkg::ST_SCAN;
                    end
                end
            end
            rhr_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    n_state = (r_mode == rhr_pkg::MODE_REGISTER) ? rhr_pkg::ST_EMIT
                                                                 : rhr_pkg::ST_UNREG_WR;
                end else if (scan_end) begin
                    n_state = (r_mode == rhr_pkg::MODE_REGISTER) ? rhr_pkg::ST_REG_CHK
                                                                 : rhr_pkg::ST_EMIT;
                end
            end
            rhr_pkg::ST_REG_CHK:   n_state = rhr_pkg::ST_EMIT;
            rhr_pkg::ST_UNREG_WR:  n_state = rhr_pkg::ST_UNREG_REF;
            rhr_pkg::ST_UNREG_REF: n_state = rhr_pkg::ST_TRIM;
            rhr_pkg::ST_TRIM: begin
                if (!trim_more) n_state = rhr_pkg::ST_EMIT;
            end
            rhr_pkg::ST_GET_CHK: begin
                n_state = (r_slot_q == '0) ? rhr_pkg::ST_EMIT : rhr_pkg::ST_GET_REF;
            end
            rhr_pkg::ST_GET_REF:   n_state = rhr_pkg::ST_EMIT;
            rhr_pkg::ST_PUT_CHK:   n_state = rhr_pkg::ST_EMIT;
            rhr_pkg::ST_EMIT: begin
                if (out_free) n_state = rhr_pkg::ST_IDLE;
            end
            default: n_state = rhr_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_limit      = r_limit;
        n_live       = r_live;
        n_clr        = r_clr;
        n_mode       = r_mode;
        n_dev        = r_dev;
        n_ptr        = r_ptr;
        n_vac_ok     = r_vac_ok;
        n_vac        = r_vac;
        n_hit        = r_hit;
        n_res_status = r_res_status;
        n_res_dev    = r_res_dev;
        n_res_slot   = r_res_slot;
        n_res_rel    = r_res_rel;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_data   = r_out_data;
        slot_we      = 1'b0;
        slot_wa      = '0;
        slot_wd      = '0;
        slot_re      = 1'b0;
        slot_ra      = '0;
        ref_cmd      = '{rd: 1'b0, wr: 1'b0, op: rhr_pkg::REF_CLEAR};
        ref_addr     = r_dev;

        unique case (r_state)
            rhr_pkg::ST_CLEAR: begin
                slot_we    = (32'(r_clr) < SLOTS);
                slot_wa    = SAW'(r_clr);
                ref_addr   = IAW'(r_clr);
                ref_cmd.wr = (32'(r_clr) < IDENTITIES);
                n_clr      = r_clr + CW'(1);
            end
            rhr_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_mode       = in_mode;
                    n_dev        = IAW'(in_dev);
                    n_ptr        = '0;
                    n_vac_ok     = 1'b0;
                    n_res_status = rhr_pkg::STAT_OK;
                    n_res_dev    = '0;
                    n_res_slot   = '0;
                    n_res_rel    = 1'b0;
                    if (in_mode == rhr_pkg::MODE_GET) begin
                        if (get_in_range) begin
                            slot_re = 1'b1;
                            slot_ra = SAW'(in_idx);
                        end else begin
                            n_res_status = rhr_pkg::STAT_NOTFOUND;
                        end
                    end else if (in_dev_bad) begin
                        n_res_status = rhr_pkg::STAT_NODEV;
                    end else if (in_mode == rhr_pkg::MODE_PUT) begin
                        ref_cmd.rd = 1'b1;
                        ref_addr   = IAW'(in_dev);
                    end
                end
            end
            rhr_pkg::ST_SCAN: begin
                // one slot read issued per cycle, checked the cycle after
                if (r_ptr != r_limit) begin
                    slot_re = 1'b1;
                    slot_ra = SAW'(r_ptr);
                    n_ptr   = r_ptr + LW'(1);
                end
                if (scan_hit) begin
                    if (r_mode == rhr_pkg::MODE_REGISTER) begin
                        n_res_status = rhr_pkg::STAT_INUSE;
                    end else begin
                        n_hit = r_q_idx;
                    end
                end else begin
                    if (scan_vac) begin
                        n_vac_ok = 1'b1;
                        n_vac    = r_q_idx;
                    end
                    if (scan_end) begin
                        if (r_mode == rhr_pkg::MODE_REGISTER) begin
                            ref_cmd.rd = 1'b1;
                        end else begin
                            n_res_status = rhr_pkg::STAT_NOTFOUND;
                        end
                    end
                end
            end
            rhr_pkg::ST_REG_CHK: begin
                if (ref_stat.busy) begin
                    n_res_status = rhr_pkg::STAT_INUSE;
                end else if (!r_vac_ok && (32'(r_limit) == SLOTS)) begin
                    n_res_status = rhr_pkg::STAT_FULL;
                end else begin
                    slot_we    = 1'b1;
                    slot_wa    = r_vac_ok ? r_vac : SAW'(r_limit);
                    slot_wd    = r_dev;
                    if (!r_vac_ok) n_limit = r_limit + LW'(1);
                    n_live     = r_live + LW'(1);
                    ref_cmd.wr = 1'b1;
                    ref_cmd.op = rhr_pkg::REF_CLAIM;
                    n_res_slot = rhr_pkg::SLOT_IDX_W'(slot_wa);
                end
            end
            rhr_pkg::ST_UNREG_WR: begin
                slot_we    = 1'b1;
                slot_wa    = r_hit;
                if (r_live != '0) n_live = r_live - LW'(1);
                ref_cmd.rd = 1'b1;
                n_res_slot = rhr_pkg::SLOT_IDX_W'(r_hit);
            end
            rhr_pkg::ST_UNREG_REF: begin
                ref_cmd.wr = 1'b1;
                ref_cmd.op = rhr_pkg::REF_RETIRE;
                n_res_rel  = ref_stat.last_ref;
                // top used slot, seen after the free above has landed
                slot_re    = 1'b1;
                slot_ra    = SAW'(r_limit - LW'(1));
            end
            rhr_pkg::ST_TRIM: begin
                if (r_slot_q == '0) begin
                    n_limit = r_limit - LW'(1);
                    if (trim_more) begin
                        slot_re = 1'b1;
                        slot_ra = SAW'(r_limit - LW'(2));
                    end
                end
            end
            rhr_pkg::ST_GET_CHK: begin
                if (r_slot_q == '0) begin
                    n_res_status = rhr_pkg::STAT_NOTFOUND;
                end else begin
                    n_dev      = r_slot_q;
                    ref_cmd.rd = 1'b1;
                    ref_addr   = r_slot_q;
                end
            end
            rhr_pkg::ST_GET_REF: begin
                if (ref_stat.at_max) begin
                    n_res_status = rhr_pkg::STAT_REFUSED;
                end else begin
                    ref_cmd.wr = 1'b1;
                    ref_cmd.op = rhr_pkg::REF_TAKE;
                    n_res_dev  = rhr_pkg::DEVICE_W'(r_dev);
                end
            end
            rhr_pkg::ST_PUT_CHK: begin
                if (ref_stat.put_refused) begin
                    n_res_status = rhr_pkg::STAT_REFUSED;
                end else begin
                    ref_cmd.wr = 1'b1;
                    ref_cmd.op = rhr_pkg::REF_DROP;
                    n_res_rel  = ref_stat.last_ref;
                end
            end
            rhr_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {rhr_pkg::LIVE_W'(r_limit), rhr_pkg::LIVE_W'(r_live),
                                   r_res_rel, r_res_slot, r_res_dev, r_res_status};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rhr_pkg::ST_CLEAR;
            r_limit     <= '0;
            r_live      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_q_v       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_limit     <= n_limit;
            r_live      <= n_live;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_q_v       <= slot_re;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_dev        <= n_dev;
        r_ptr        <= n_ptr;
        r_vac_ok     <= n_vac_ok;
        r_vac        <= n_vac;
        r_hit        <= n_hit;
        r_res_status <= n_res_status;
        r_res_dev    <= n_res_dev;
        r_res_slot   <= n_res_slot;
        r_res_rel    <= n_res_rel;
        r_out_data   <= n_out_data;
    end

    // slot owner memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            mem_slot[slot_wa] <= slot_wd;
        end
        if (slot_re) begin
            r_slot_q <= mem_slot[slot_ra];
            r_q_idx  <= slot_ra;
        end
    end

endmodule

[design/rhr_ref_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhr_ref_table
// per-identity record store (registered mark + reference count) with a
// registered read port and read-modify-write update of the last read entry
// ----------------------------------------------------------------------------
module rhr_ref_table #(
    parameter int IDENTITIES  = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic [$clog2(IDENTITIES)-1:0] i_addr,
    input  rhr_pkg::t_ref_cmd             i_cmd,
    output rhr_pkg::t_ref_stat            o_stat
);

    logic [COUNT_WIDTH:0]   mem_rec [IDENTITIES];
    logic [COUNT_WIDTH:0]   r_q;
    logic [COUNT_WIDTH:0]   n_rec;
    logic [COUNT_WIDTH-1:0] q_count;
    logic                   q_reg;
    logic                   q_zero;
    logic                   q_one;

    assign q_count = r_q[COUNT_WIDTH-1:0];
    assign q_reg   = r_q[COUNT_WIDTH];
    assign q_zero  = (q_count == '0);
    assign q_one   = (q_count == COUNT_WIDTH'(1));

    assign o_stat.busy        = q_reg || !q_zero;
    assign o_stat.at_max      = &q_count;
    assign o_stat.put_refused = q_zero || (q_reg && q_one);
    assign o_stat.last_ref    = q_one;

    // new record from the entry read in the previous cycle
    always_comb begin
        case (i_cmd.op)
            rhr_pkg::REF_CLAIM:  n_rec = {1'b1, COUNT_WIDTH'(1)};
            rhr_pkg::REF_TAKE:   n_rec = {q_reg, q_count + COUNT_WIDTH'(1)};
            rhr_pkg::REF_DROP:   n_rec = {q_reg, q_count - COUNT_WIDTH'(1)};
            rhr_pkg::REF_RETIRE: n_rec = {1'b0, q_zero ? q_count : q_count - COUNT_WIDTH'(1)};
            default:             n_rec = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem_rec[i_addr] <= n_rec;
        end
        if (i_cmd.rd) begin
            r_q <= mem_rec[i_addr];
        end
    end

endmodule

[design/rhr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhr_checker
// port-level checks of the refcounted handle registry, bound to the top level
// ----------------------------------------------------------------------------
`include "refcounted_handle_registry_unit_defines.svh"

module rhr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            i_s_axis_tready,
    input logic                            i_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [rhr_pkg::OUT_TDATA_W-1:0] i_m_axis_tdata
);

    logic                         out_stall;
    logic                         in_take;
    logic [rhr_pkg::STATUS_W-1:0] out_status;

    assign out_stall  = i_m_axis_tvalid && !i_m_axis_tready;
    assign in_take    = i_s_axis_tvalid && i_s_axis_tready;
    assign out_status = i_m_axis_tdata[2:0];

    // reset leaves no result pending
    `RHR_ASSERT_ALWAYS_NEXT(a_reset_quiet, !i_rst_n, !i_m_axis_tvalid, "result valid after reset")

    // a stalled result keeps its payload
    `RHR_ASSERT_NEXT(a_out_hold, out_stall, i_m_axis_tvalid && $stable(i_m_axis_tdata), "stalled result changed")

    // one transaction at a time: no accept right after an accept
    `RHR_ASSERT_NEXT(a_one_inflight, in_take, !i_s_axis_tready, "input taken back to back")

    // a release comes only with a successful operation
    `RHR_ASSERT_IMPLIES(a_release_ok, i_m_axis_tvalid && i_m_axis_tdata[13], out_status == rhr_pkg::STAT_OK, "release on failed operation")

    // full means every slot below the limit is occupied
    `RHR_ASSERT_IMPLIES(a_full_count, i_m_axis_tvalid && (out_status == rhr_pkg::STAT_FULL), i_m_axis_tdata[18:14] == i_m_axis_tdata[23:19], "full with a vacancy")

endmodule

bind refcounted_handle_registry_unit rhr_checker u_rhr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);
